// ----- hw/rtl/quadratic_root_solver_top_assert.svh -----
// Assertion macros for the quadratic root solver checker.
// Used by the checker file only.
`ifndef QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define QRS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define QRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- hw/rtl/qrs_pkg.sv -----
// Package for the quadratic root solver: category codes, payload types and sizes.
// No dependencies.
`default_nettype none
package qrs_pkg;
	localparam int CW = 16;
	localparam int RW = 32;
	localparam int DW = 2*CW + 3;
	localparam int SW = CW + 2;
	localparam int NW = SW + 2 + 16;
	localparam int QW = NW;
	typedef enum logic [1:0] {
		CAT_NONE    = 2'd0,
		CAT_DISTINCT = 2'd1,
		CAT_EQUAL   = 2'd2,
		CAT_COMPLEX = 2'd3
	} cat_t;
	typedef struct packed {
		logic signed [CW-1:0] coef_a;
		logic signed [CW-1:0] coef_b;
		logic signed [CW-1:0] coef_c;
	} coef_t;
	typedef struct packed {
		cat_t                  cat;
		logic signed [NW-1:0] num1;
		logic signed [NW-1:0] num2;
		logic signed [CW+1:0] den;
	} work_t;
	typedef struct packed {
		cat_t                 category;
		logic signed [RW-1:0] root_one;
		logic signed [RW-1:0] root_two;
		logic                 saturated;
	} res_t;
endpackage
`default_nettype wire

// ----- hw/rtl/qrs_if.sv -----
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
`default_nettype none
interface qrs_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/qrs_front.sv -----
// Front: discriminant, pipelined square root, classification.
// Depends on qrs_pkg.
`default_nettype none
module qrs_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic [3*qrs_pkg::CW-1:0] in_data,
	input  wire logic                     en,
	output logic                          out_valid,
	output qrs_pkg::work_t                out_data
);
	import qrs_pkg::*;
	localparam int RB = DW/2 + 1;   // root bits
	logic signed [CW-1:0] a_in, b_in, c_in;
	assign a_in = in_data[3*CW-1:2*CW];
	assign b_in = in_data[2*CW-1:CW];
	assign c_in = in_data[CW-1:0];
	// stage 1: products
	logic signed [2*CW:0] bb_s1, ac_s1;
	logic signed [CW-1:0] a_s1, b_s1;
	logic v_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			bb_s1 <= (2*CW+1)'(b_in * b_in);
			ac_s1 <= (2*CW+1)'(a_in * c_in);
			a_s1 <= a_in; b_s1 <= b_in;
		end
	end
	logic signed [DW-1:0] d_c;
	assign d_c = DW'(bb_s1) - (DW'(ac_s1) <<< 2);
	// square root pipeline: one result bit per stage
	logic [DW-1:0]       rem_p [0:RB];
	logic [RB-1:0]       rt_p  [0:RB];
	logic signed [CW-1:0] a_p [0:RB];
	logic signed [CW-1:0] b_p [0:RB];
	logic [1:0]          sg_p  [0:RB];   // {neg, zero}
	logic                v_p   [0:RB];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_p[0] <= 1'b0;
		else if (en) v_p[0] <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rem_p[0] <= d_c[DW-1] ? DW'(-d_c) : DW'(d_c);
			rt_p[0]  <= '0;
			a_p[0] <= a_s1; b_p[0] <= b_s1;
			sg_p[0] <= {d_c[DW-1], d_c == '0};
		end
	end
	for (genvar k = 0; k < RB; k++) begin : g_sq
		localparam int SH = 2*(RB-1-k);
		logic [DW+1:0] trial, remx;
		logic [RB-1:0] cand;
		always_comb begin
			cand  = rt_p[k] | (RB'(1) << (RB-1-k));
			trial = (DW+2)'(cand) * (DW+2)'(cand);
			remx  = (DW+2)'(rem_p[k]);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_p[k+1] <= 1'b0;
			else if (en) v_p[k+1] <= v_p[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_p[k+1] <= rem_p[k];
				rt_p[k+1]  <= (trial <= remx) ? cand : rt_p[k];
				a_p[k+1] <= a_p[k]; b_p[k+1] <= b_p[k];
				sg_p[k+1] <= sg_p[k];
			end
		end
	end
	// classify and form numerators, already scaled by 2^16
	work_t w_c;
	logic signed [NW-1:0] nb, sv;
	always_comb begin
		nb = -(NW'(b_p[RB]));
		sv = NW'($signed({1'b0, rt_p[RB]}));
		w_c.den = (CW+2)'(a_p[RB]) <<< 1;
		w_c.cat = CAT_NONE;
		w_c.num1 = '0;
		w_c.num2 = '0;
		if (a_p[RB] != '0) begin
			if (sg_p[RB][0]) begin
				w_c.cat = CAT_EQUAL; w_c.num1 = nb <<< 16; w_c.num2 = nb <<< 16;
			end else if (sg_p[RB][1]) begin
				w_c.cat = CAT_COMPLEX; w_c.num1 = nb <<< 16; w_c.num2 = sv <<< 16;
			end else begin
				w_c.cat = CAT_DISTINCT;
				w_c.num1 = (nb + sv) <<< 16; w_c.num2 = (nb - sv) <<< 16;
			end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_p[RB];
	end
	always_ff @(posedge clk) begin
		if (en) out_data <= w_c;
	end
endmodule
`default_nettype wire

// ----- hw/rtl/qrs_fifo.sv -----
// Short queue between front and back.
// Depends on qrs_pkg.
`default_nettype none
module qrs_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire qrs_pkg::work_t wr_data,
	input  wire logic           rd_en,
	output qrs_pkg::work_t      rd_data,
	output logic                empty,
	output logic [2:0]          count
);
	import qrs_pkg::*;
	work_t mem_q [0:3];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 2'd1;
			if (rd_en) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr_en) - 3'(rd_en);
		end
	end
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end
	assign rd_data = mem_q[rp_q];
	assign empty = (cnt_q == '0);
	assign count = cnt_q;
endmodule
`default_nettype wire

// ----- hw/rtl/qrs_back.sv -----
// Back: pipelined restoring divider for both roots, then clipping.
// Depends on qrs_pkg.
`default_nettype none
module qrs_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire qrs_pkg::work_t in_data,
	output logic                out_valid,
	output qrs_pkg::res_t       out_data
);
	import qrs_pkg::*;
	localparam int DV = CW + 2;
	logic [QW-1:0] q1_p [0:QW], q2_p [0:QW];
	logic [DV:0]   r1_p [0:QW], r2_p [0:QW];
	logic [DV-1:0] dm_p [0:QW];
	logic [1:0]    ng_p [0:QW];
	cat_t          ct_p [0:QW];
	logic          v_p  [0:QW];
	logic [NW-1:0] m1, m2;
	logic [DV-1:0] dm;
	always_comb begin
		m1 = in_data.num1[NW-1] ? NW'(-in_data.num1) : NW'(in_data.num1);
		m2 = in_data.num2[NW-1] ? NW'(-in_data.num2) : NW'(in_data.num2);
		dm = in_data.den[DV-1] ? DV'(-in_data.den) : DV'(in_data.den);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_p[0] <= 1'b0;
		else if (en) v_p[0] <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			q1_p[0] <= m1; q2_p[0] <= m2; r1_p[0] <= '0; r2_p[0] <= '0;
			dm_p[0] <= dm; ct_p[0] <= in_data.cat;
			ng_p[0] <= {in_data.num1[NW-1] ^ in_data.den[DV-1],
				in_data.num2[NW-1] ^ in_data.den[DV-1]};
		end
	end
	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [DV:0] t1, t2, d1, d2;
		always_comb begin
			t1 = {r1_p[k][DV-1:0], q1_p[k][QW-1]};
			t2 = {r2_p[k][DV-1:0], q2_p[k][QW-1]};
			d1 = t1 - (DV+1)'(dm_p[k]);
			d2 = t2 - (DV+1)'(dm_p[k]);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_p[k+1] <= 1'b0;
			else if (en) v_p[k+1] <= v_p[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r1_p[k+1] <= d1[DV] ? t1 : d1;
				r2_p[k+1] <= d2[DV] ? t2 : d2;
				q1_p[k+1] <= {q1_p[k][QW-2:0], ~d1[DV]};
				q2_p[k+1] <= {q2_p[k][QW-2:0], ~d2[DV]};
				dm_p[k+1] <= dm_p[k]; ng_p[k+1] <= ng_p[k]; ct_p[k+1] <= ct_p[k];
			end
		end
	end
	localparam logic signed [QW:0] HI = (QW+1)'((64'sd1 <<< (RW-1)) - 1);
	localparam logic signed [QW:0] LO = -HI - 1;
	logic signed [QW:0] s1, s2;
	logic o1h, o1l, o2h, o2l;
	res_t r_c;
	always_comb begin
		s1 = ng_p[QW][1] ? -$signed({1'b0, q1_p[QW]}) : $signed({1'b0, q1_p[QW]});
		s2 = ng_p[QW][0] ? -$signed({1'b0, q2_p[QW]}) : $signed({1'b0, q2_p[QW]});
		o1h = s1 > HI; o1l = s1 < LO; o2h = s2 > HI; o2l = s2 < LO;
		r_c.category = ct_p[QW];
		r_c.root_one = o1h ? RW'(HI) : o1l ? RW'(LO) : RW'(s1);
		r_c.root_two = o2h ? RW'(HI) : o2l ? RW'(LO) : RW'(s2);
		r_c.saturated = o1h | o1l | o2h | o2l;
		if (ct_p[QW] == CAT_NONE) begin
			r_c.root_one = '0; r_c.root_two = '0; r_c.saturated = 1'b0;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_p[QW];
	end
	always_ff @(posedge clk) begin
		if (en) out_data <= r_c;
	end
endmodule
`default_nettype wire

// ----- hw/rtl/quadratic_root_solver_top.sv -----
// Quadratic root solver top level: coefficient channel in, root channel out.
// Depends on qrs_pkg, qrs_if, qrs_front, qrs_fifo, qrs_back.
//
// Usage:
//  coef: sink channel, payload coef_t {coef_a, coef_b, coef_c}, signed Q8.8.
//  res:  source channel, payload category/root_one/root_two/saturated.
//  One transfer in, exactly one transfer out, in order.
// Throughput: one item per cycle while res is ready.
// Stages: the front has 21 register stages (products, discriminant
//  magnitude, 18 square-root bits, classify), the queue one, the back 38
//  (load, 36 quotient bits, output register).
// Stalls: front and back each freeze as a whole pipeline when they cannot
//  advance. The four-entry queue lets the front keep taking items while the
//  back is stalled; coef.ready drops only once the queue is full and nothing
//  leaves it, and the items inside the front then wait in place.
// Reset: arst_n clears all valid flags and queue pointers; payload
//  registers are not reset. No clearing pass is needed.
`default_nettype none
module quadratic_root_solver_top (
	input wire logic clk,
	input wire logic arst_n,
	qrs_if.sink      coef,
	qrs_if.source    res
);
	import qrs_pkg::*;
	work_t f_data, q_data;
	logic f_valid, q_empty, f_en, b_en, b_valid, rd;
	logic [2:0] q_cnt;
	res_t b_data;
	// front stalls only when the queue is full and nothing leaves it
	assign f_en = (q_cnt != 3'd4) || rd || !f_valid;
	// the front input stage moves with the rest of the front
	assign coef.ready = f_en;
	// back advances when its output is free
	assign b_en = !res.valid || res.ready;
	assign rd = b_en && !q_empty;
	qrs_front u_front (
		.clk, .arst_n, .in_valid(coef.valid && coef.ready),
		.in_data({coef.data.coef_a, coef.data.coef_b, coef.data.coef_c}),
		.en(f_en), .out_valid(f_valid), .out_data(f_data)
	);
	qrs_fifo u_fifo (
		.clk, .arst_n, .wr_en(f_valid && f_en), .wr_data(f_data),
		.rd_en(rd), .rd_data(q_data), .empty(q_empty), .count(q_cnt)
	);
	qrs_back u_back (
		.clk, .arst_n, .en(b_en), .in_valid(rd), .in_data(q_data),
		.out_valid(b_valid), .out_data(b_data)
	);
	assign res.valid = b_valid;
	always_comb begin
		res.data.category  = b_data.category;
		res.data.root_one  = b_data.root_one;
		res.data.root_two  = b_data.root_two;
		res.data.saturated = b_data.saturated;
	end
endmodule
`default_nettype wire

// ----- hw/rtl/qrs_checker.sv -----
// Port-level checker for the quadratic root solver, bound to the top.
// Depends on qrs_pkg and quadratic_root_solver_top_assert.svh.
`default_nettype none
`include "quadratic_root_solver_top_assert.svh"
module qrs_port_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [1:0] category,
	input wire logic [31:0] root_one,
	input wire logic [31:0] root_two,
	input wire logic       saturated
);
	import qrs_pkg::*;
	logic stall, is_none, is_equal, zero_out;
	assign stall    = res_valid && !res_ready;
	assign is_none  = res_valid && (category == CAT_NONE);
	assign is_equal = res_valid && (category == CAT_EQUAL);
	assign zero_out = (root_one == '0) && (root_two == '0) && !saturated;
	`QRS_ASSERT_NEXT(a_hold, clk, arst_n, stall, res_valid && $stable(root_one), "result dropped")
	`QRS_ASSERT_IMPL(a_none, clk, arst_n, is_none, zero_out, "nonzero roots for linear input")
	`QRS_ASSERT_IMPL(a_equal, clk, arst_n, is_equal, root_one == root_two, "equal roots differ")
endmodule
bind quadratic_root_solver_top qrs_port_checker u_chk (
	.clk(clk), .arst_n(arst_n), .res_valid(res.valid), .res_ready(res.ready),
	.category(res.data.category), .root_one(res.data.root_one),
	.root_two(res.data.root_two), .saturated(res.data.saturated)
);
`default_nettype wire

// ----- test/qrs_checker.sv -----
// Checker for the quadratic root solver: watches both channels, predicts roots.
// Depends on qrs_pkg and qrs_if.
`default_nettype none
module qrs_checker (
	input wire logic clk,
	input wire logic arst_n,
	qrs_if           coef,
	qrs_if           res,
	output int       fail_count,
	output int       pending
);
	import qrs_pkg::*;

	res_t roots_due[$];

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned r, bt;
		r = 0;
		bt = 64'd1 << 62;
		while (bt > v)
			bt = bt >> 2;
		while (bt != 0) begin
			if (v >= r + bt) begin
				v = v - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r;
	endfunction

	// Q16.16 quotient, clipped to 32 bits; sets sat on clipping.
	function automatic logic signed [31:0] root_div(input longint num, input longint dv,
			inout logic sat);
		longint q;
		q = (num * 65536) / dv;
		if (q > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7fffffff;
		end
		if (q < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'sh80000000;
		end
		return q[31:0];
	endfunction

	function automatic res_t solve_roots(input coef_t abc);
		res_t r;
		longint a, b, c, disc, dv, s;
		logic sat;
		a = longint'(abc.coef_a);
		b = longint'(abc.coef_b);
		c = longint'(abc.coef_c);
		sat = 1'b0;
		r = '0;
		r.category = CAT_NONE;
		if (a != 0) begin
			disc = b * b - 4 * a * c;
			dv = 2 * a;
			s = longint'(floor_sqrt(disc < 0 ? -disc : disc));
			if (disc > 0) begin
				r.category = CAT_DISTINCT;
				r.root_one = root_div(-b + s, dv, sat);
				r.root_two = root_div(-b - s, dv, sat);
			end else if (disc == 0) begin
				r.category = CAT_EQUAL;
				r.root_one = root_div(-b, dv, sat);
				r.root_two = r.root_one;
			end else begin
				r.category = CAT_COMPLEX;
				r.root_one = root_div(-b, dv, sat);
				r.root_two = root_div(s, dv, sat);
			end
			r.saturated = sat;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
			roots_due.delete();
		end else begin
			if (coef.valid && coef.ready)
				roots_due.push_back(solve_roots(coef.data));
			if (res.valid && res.ready) begin
				if (roots_due.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result transfer: %p", res.data);
				end else begin
					want = roots_due.pop_front();
					if (res.data.category !== want.category ||
							res.data.root_one !== want.root_one ||
							res.data.root_two !== want.root_two ||
							res.data.saturated !== want.saturated) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
								want.category, want.root_one, want.root_two, want.saturated,
								res.data.category, res.data.root_one, res.data.root_two,
								res.data.saturated);
					end
				end
			end
			pending <= roots_due.size();
		end
	end
endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Testbench top for quadratic_root_solver_top: stimulus, flow control, verdict.
// Depends on qrs_pkg, qrs_if, qrs_checker and the solver RTL.
`default_nettype none
module tb;
	import qrs_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_ITEMS = 1880;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   stall_run;
	int   cyc;

	qrs_if #(.T(coef_t)) coef (clk);
	qrs_if #(.T(res_t))  res (clk);

	quadratic_root_solver_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.coef   (coef),
		.res    (res)
	);

	qrs_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.coef       (coef),
		.res        (res),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 4-unit clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Idle-transfer watchdog; the long receiver hold-off stays well under it.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if ((coef.valid && coef.ready) || (res.valid && res.ready))
			stall_run <= 0;
		else
			stall_run <= stall_run + 1;
		if (stall_run >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result side: ~19% random stalls, a quiet window with none, and one long
	// hold-off while the sender keeps offering so the internal queue backs up.
	initial begin
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (cyc == 1500) begin
				res.ready <= 1'b0;
				repeat (400) @(negedge clk);
			end
			if (cyc > 300 && cyc < 800)
				res.ready <= 1'b1;
			else
				res.ready <= ($urandom_range(99) >= 19);
		end
	end

	// Offer one coefficient triple; valid stays high across back-to-back items.
	task automatic put_coefs(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c, input bit may_idle);
		if (may_idle) begin
			while ($urandom_range(99) < 19) begin
				coef.valid <= 1'b0;
				@(negedge clk);
			end
		end
		coef.valid <= 1'b1;
		coef.data <= {a, b, c};
		do @(posedge clk); while (!coef.ready);
		@(negedge clk);
	endtask

	// Random triple biased toward interesting shapes.
	task automatic put_random(input bit may_idle);
		logic [15:0] a, b, c;
		int k, m;
		case ($urandom_range(9))
			0, 1, 2: begin
				a = 16'($urandom);
				b = 16'($urandom);
				c = 16'($urandom);
			end
			3: begin
				// perfect square: repeated root
				k = int'($urandom_range(1, 60));
				m = int'($urandom_range(0, 20));
				a = 16'(($urandom_range(1) != 0) ? k : -k);
				b = 16'(2 * k * m * (($urandom_range(1) != 0) ? 1 : -1));
				c = 16'(k * m * m);
				if ($signed(a) < 0)
					c = -c;
			end
			4: begin
				// tiny a: large roots, often clipped
				a = 16'($urandom_range(1, 4));
				if ($urandom_range(1) != 0)
					a = -a;
				b = 16'($urandom);
				c = 16'($urandom);
			end
			5: begin
				a = 16'd0;
				b = 16'($urandom);
				c = 16'($urandom);
			end
			6: begin
				// complex pair: a and c of same sign, small b
				a = 16'($urandom_range(1, 32767));
				c = 16'($urandom_range(1, 32767));
				b = 16'($urandom_range(0, 255));
				if ($urandom_range(1) != 0) begin
					a = -a;
					c = -c;
				end
			end
			default: begin
				a = 16'($urandom_range(0, 1023) - 512);
				b = 16'($urandom_range(0, 4095) - 2048);
				c = 16'($urandom_range(0, 4095) - 2048);
			end
		endcase
		put_coefs(a, b, c, may_idle);
	endtask

	initial begin
		cyc = 0;
		stall_run = 0;
		arst_n = 1'b0;
		coef.valid = 1'b0;
		coef.data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed corners
		put_coefs(16'h0000, 16'h1234, 16'h5678, 1);   // not quadratic
		put_coefs(16'h0000, 16'h0000, 16'h0000, 1);
		put_coefs(16'h0100, 16'h0000, 16'hFC00, 1);   // x^2 - 4: distinct
		put_coefs(16'h0100, 16'h0200, 16'h0100, 1);   // x^2+2x+1: repeated
		put_coefs(16'h0100, 16'h0000, 16'h0100, 1);   // x^2+1: complex
		put_coefs(16'hFF00, 16'h0000, 16'hFF00, 1);   // complex, negative a
		put_coefs(16'h0001, 16'h8000, 16'h0000, 1);   // huge roots, clipped
		put_coefs(16'h0001, 16'h7FFF, 16'h7FFF, 1);
		put_coefs(16'hFFFF, 16'h7FFF, 16'h8000, 1);
		put_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF, 1);
		put_coefs(16'h8000, 16'h8000, 16'h8000, 1);
		put_coefs(16'h8000, 16'h7FFF, 16'h7FFF, 1);   // large positive disc
		put_coefs(16'h7FFF, 16'h0000, 16'h7FFF, 1);   // large negative disc
		put_coefs(16'h8000, 16'h0000, 16'h0000, 1);   // zero disc, b zero
		put_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
		put_coefs(16'h0001, 16'h0000, 16'h8000, 1);
		put_coefs(16'h5555, 16'hAAAA, 16'h5555, 1);
		put_coefs(16'hAAAA, 16'h5555, 16'hAAAA, 1);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// pause until every result has come, once mid-run
			if (i == RANDOM_ITEMS / 2) begin
				coef.valid <= 1'b0;
				while (pending != 0)
					@(negedge clk);
			end
			put_random(!(cyc > 300 && cyc < 800));
		end
		coef.valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire
